/* hdl/sliding_window_count_min_sketch_assert.svh */
// Assertion macros shared by the sketch RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef SLIDING_WINDOW_COUNT_MIN_SKETCH_ASSERT_SVH
`define SLIDING_WINDOW_COUNT_MIN_SKETCH_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SWCMS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sketch assertion failed");

// Next-cycle implication, off while reset is high.
`define SWCMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sketch assertion failed");

`endif

/* hdl/swcms_pkg.sv */
// Shared constants and types for the sliding-window count-min sketch.
// No dependencies; the interfaces, the lane unit and the top level import this package.
package swcms_pkg;

   localparam int ROWS       = 4;
   localparam int COLUMNS    = 1024;
   localparam int LANES      = 4;
   localparam int LANE_W     = 16;
   localparam int WORD_W     = LANES * LANE_W;
   localparam int IDX_W      = 10;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH      = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int LANE_SEL_W = $clog2(LANES);
   localparam int CMD_W      = 2;
   localparam int LOOKBACK_W = 16;
   localparam int EPOCH_W    = 16;
   localparam int EST_W      = 18;
   localparam int COUNT_W    = 32;
   localparam int CFG_W      = 32;

   localparam logic [CFG_W-1:0]  WINDOW_RESET = 32'd1024;
   localparam logic [LANE_W-1:0] LANE_MAX     = 16'hffff;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] count_word;
      logic [WORD_W-1:0] stamp_word;
      logic [LANE_W-1:0] term;
   } lane_res_type;

endpackage

/* hdl/swcms_req_if.sv */
// Request and response channel interfaces of the sketch.
// Depends on swcms_pkg for field widths.
interface swcms_req_if;
   import swcms_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [IDX_W-1:0]      row0_index;
   logic [IDX_W-1:0]      row1_index;
   logic [IDX_W-1:0]      row2_index;
   logic [IDX_W-1:0]      row3_index;
   logic [LOOKBACK_W-1:0] lookback;

   modport source (output valid, cmd, row0_index, row1_index, row2_index, row3_index,
                   lookback, input ready);
   modport sink   (input valid, cmd, row0_index, row1_index, row2_index, row3_index,
                   lookback, output ready);
endinterface

interface swcms_rsp_if;
   import swcms_pkg::*;

   logic               valid;
   logic               ready;
   logic [EST_W-1:0]   estimate;
   logic [COUNT_W-1:0] item_count;

   modport source (output valid, estimate, item_count, input ready);
   modport sink   (input valid, estimate, item_count, output ready);
endinterface

/* hdl/swcms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module swcms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/swcms_lane_alu.sv */
// Lane unit: updates one lane of a count/stamp entry and gives its windowed term.
// Depends on swcms_pkg.
module swcms_lane_alu (
   input  logic [swcms_pkg::WORD_W-1:0]     count_word,
   input  logic [swcms_pkg::WORD_W-1:0]     stamp_word,
   input  logic [swcms_pkg::LANE_SEL_W-1:0] lane,
   input  logic [swcms_pkg::EPOCH_W-1:0]    epoch,
   input  logic [swcms_pkg::LOOKBACK_W-1:0] lookback,
   output swcms_pkg::lane_res_type          res
);
   import swcms_pkg::*;

   logic [LANE_W-1:0] count_lane;
   logic [LANE_W-1:0] stamp_lane;
   logic [LANE_W-1:0] count_new;
   logic [LANE_W-1:0] age;
   logic              fresh;

   always_comb begin
      count_lane = count_word[lane*LANE_W +: LANE_W];
      stamp_lane = stamp_word[lane*LANE_W +: LANE_W];
      fresh      = (stamp_lane == LANE_W'(epoch));
      // stale lane restarts at one; live lane saturates
      if (!fresh) begin
         count_new = LANE_W'(1);
      end else if (count_lane == LANE_MAX) begin
         count_new = count_lane;
      end else begin
         count_new = count_lane + LANE_W'(1);
      end
      age      = LANE_W'(epoch) - stamp_lane;
      res.term = (age <= LANE_W'(lookback)) ? count_lane : '0;
      res.count_word = count_word;
      res.stamp_word = stamp_word;
      for (int l = 0; l < LANES; l++) begin
         if (LANE_SEL_W'(l) == lane) begin
            res.count_word[l*LANE_W +: LANE_W] = count_new;
            res.stamp_word[l*LANE_W +: LANE_W] = LANE_W'(epoch);
         end
      end
   end
endmodule

/* hdl/sliding_window_count_min_sketch.sv */
// Top level of the sliding-window count-min sketch: sequencer, counters, output register.
// Depends on swcms_pkg, swcms_req_if/swcms_rsp_if, swcms_ram, swcms_lane_alu.
//
//   channel | direction | payload                                      | handshake
//   req     | in        | cmd, row0..row3_index, lookback              | valid/ready
//   rsp     | out       | estimate, item_count                         | valid/ready
//   csr     | in        | epoch length (csr_write_data)                | csr_write_enable
//
// Insert: read + update per row, rows in turn, then result.
// Query: read, one lane per cycle through the lane unit, min per row.
// Clear: all ROWS*COLUMNS entries, one entry of both stores written per cycle.
// After reset a clearing pass over all ROWS*COLUMNS entries runs; req.ready stays low.
// req.ready is high only while the sequencer idles; a waiting result does not block it.
`include "sliding_window_count_min_sketch_assert.svh"

module sliding_window_count_min_sketch (
   input  logic                        clock,
   input  logic                        reset,
   swcms_req_if.sink                   req,
   swcms_rsp_if.source                 rsp,
   input  logic                        csr_write_enable,
   input  logic [swcms_pkg::CFG_W-1:0] csr_write_data
);
   import swcms_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_MIN, ST_FINISH, ST_CLEAR
   } state_type;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [IDX_W-1:0]      index_ff [ROWS];
   logic [IDX_W-1:0]      index_in [ROWS];
   logic [LOOKBACK_W-1:0] lookback_ff, lookback_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [LANE_SEL_W-1:0] lane_ff, lane_in;
   logic [EST_W-1:0]      acc_ff, acc_in;
   logic [EST_W-1:0]      best_ff, best_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  clr_report_ff, clr_report_in;
   logic [COUNT_W-1:0]    insert_total_ff, insert_total_in;
   logic [CFG_W-1:0]      epoch_fill_ff, epoch_fill_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [CFG_W-1:0]      window_ff, window_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EST_W-1:0]      estimate_ff, estimate_in;
   logic [COUNT_W-1:0]    item_count_ff, item_count_in;

   logic [ADDR_W-1:0]     entry_addr;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]     count_wr_data;
   logic [WORD_W-1:0]     stamp_wr_data;
   logic                  ram_rd_en;
   logic [WORD_W-1:0]     count_rd_data;
   logic [WORD_W-1:0]     stamp_rd_data;
   logic [LANE_SEL_W-1:0] alu_lane;
   lane_res_type          alu_res;
   logic [CFG_W-1:0]      win_eff;
   logic [CFG_W-1:0]      fill_next;
   logic                  last_row;
   logic                  req_clear_fire;
   logic                  at_finish;
   logic                  clear_start;
   logic                  finish_clear;

   assign entry_addr = ADDR_W'({row_ff, COL_W'(index_ff[row_ff])});
   assign alu_lane   = (cmd_ff == CMD_INSERT) ? epoch_ff[LANE_SEL_W-1:0] : lane_ff;
   assign win_eff    = (window_ff == '0) ? CFG_W'(1) : window_ff;
   assign fill_next  = epoch_fill_ff + CFG_W'(1);
   assign last_row   = (row_ff == ROW_W'(ROWS - 1));

   swcms_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (count_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (entry_addr),
      .rd_data (count_rd_data)
   );

   swcms_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (stamp_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (entry_addr),
      .rd_data (stamp_rd_data)
   );

   swcms_lane_alu u_lane_alu (
      .count_word (count_rd_data),
      .stamp_word (stamp_rd_data),
      .lane       (alu_lane),
      .epoch      (epoch_ff),
      .lookback   (lookback_ff),
      .res        (alu_res)
   );

   // memory port control
   always_comb begin
      ram_rd_en     = (state_ff == ST_READ);
      ram_wr_en     = 1'b0;
      ram_wr_addr   = entry_addr;
      count_wr_data = alu_res.count_word;
      stamp_wr_data = alu_res.stamp_word;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en     = 1'b1;
         ram_wr_addr   = clr_addr_ff;
         count_wr_data = '0;
         stamp_wr_data = '0;
      end else if (state_ff == ST_EVAL && cmd_ff == CMD_INSERT) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      index_in        = index_ff;
      lookback_in     = lookback_ff;
      row_in          = row_ff;
      lane_in         = lane_ff;
      acc_in          = acc_ff;
      best_in         = best_ff;
      clr_addr_in     = clr_addr_ff;
      clr_report_in   = clr_report_ff;
      insert_total_in = insert_total_ff;
      epoch_fill_in   = epoch_fill_ff;
      epoch_in        = epoch_ff;
      window_in       = csr_write_enable ? csr_write_data : window_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      estimate_in     = estimate_ff;
      item_count_in   = item_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd_in      = req.cmd;
               index_in[0] = req.row0_index;
               if (ROWS > 1) index_in[ROW_W'(1 % ROWS)] = req.row1_index;
               if (ROWS > 2) index_in[ROW_W'(2 % ROWS)] = req.row2_index;
               if (ROWS > 3) index_in[ROW_W'(3 % ROWS)] = req.row3_index;
               lookback_in = req.lookback;
               row_in      = '0;
               lane_in     = '0;
               acc_in      = '0;
               best_in     = '1;
               if (req.cmd == CMD_INSERT || req.cmd == CMD_QUERY) begin
                  state_in = ST_READ;
               end else if (req.cmd == CMD_CLEAR) begin
                  clr_addr_in   = '0;
                  clr_report_in = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (cmd_ff == CMD_INSERT) begin
               if (last_row) begin
                  insert_total_in = insert_total_ff + COUNT_W'(1);
                  if (fill_next >= win_eff) begin
                     epoch_fill_in = '0;
                     epoch_in      = epoch_ff + EPOCH_W'(1);
                  end else begin
                     epoch_fill_in = fill_next;
                  end
                  state_in = ST_FINISH;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = ST_READ;
               end
            end else begin
               acc_in  = acc_ff + EST_W'(alu_res.term);
               lane_in = lane_ff + LANE_SEL_W'(1);
               if (lane_ff == LANE_SEL_W'(LANES - 1)) begin
                  state_in = ST_MIN;
               end
            end
         end
         ST_MIN: begin
            best_in = (acc_ff < best_ff) ? acc_ff : best_ff;
            acc_in  = '0;
            lane_in = '0;
            if (last_row) begin
               state_in = ST_FINISH;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               estimate_in   = (cmd_ff == CMD_QUERY) ? best_ff : '0;
               item_count_in = insert_total_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               insert_total_in = '0;
               epoch_fill_in   = '0;
               epoch_in        = '0;
               state_in        = clr_report_ff ? ST_FINISH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         clr_report_ff   <= 1'b0;
         insert_total_ff <= '0;
         epoch_fill_ff   <= '0;
         epoch_ff        <= '0;
         window_ff       <= WINDOW_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         clr_report_ff   <= clr_report_in;
         insert_total_ff <= insert_total_in;
         epoch_fill_ff   <= epoch_fill_in;
         epoch_ff        <= epoch_in;
         window_ff       <= window_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      index_ff      <= index_in;
      lookback_ff   <= lookback_in;
      row_ff        <= row_in;
      lane_ff       <= lane_in;
      acc_ff        <= acc_in;
      best_ff       <= best_in;
      estimate_ff   <= estimate_in;
      item_count_ff <= item_count_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.estimate   = estimate_ff;
   assign rsp.item_count = item_count_ff;

   assign req_clear_fire = req.valid && req.ready && (req.cmd == CMD_CLEAR);
   assign at_finish      = (state_ff == ST_FINISH);
   assign clear_start    = (state_ff == ST_CLEAR) && (clr_addr_ff == '0);
   assign finish_clear   = at_finish && (cmd_ff == CMD_CLEAR);

   `SWCMS_ASSERT_IMPLIES(a_rsp_after_finish, clock, reset, $rose(rsp.valid), $past(at_finish))
   `SWCMS_ASSERT_NEXT(a_clear_starts_pass, clock, reset, req_clear_fire, clear_start)
   `SWCMS_ASSERT_IMPLIES(a_clear_zeroes_total, clock, reset, finish_clear, insert_total_ff == '0)
endmodule
